@@ sv/task_dispatch_with_overflow_stack_assert.svh @@
// Assertion macros shared by the dispatcher checks
`ifndef TASK_DISPATCH_WITH_OVERFLOW_STACK_ASSERT_SVH
`define TASK_DISPATCH_WITH_OVERFLOW_STACK_ASSERT_SVH

// check a property outside of reset
`define TDO_ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// check a property at every edge, reset included
`define TDO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/tdo_pkg.sv @@
// Shared constants and types of the task dispatcher
`default_nettype none
package tdo_pkg;

    localparam int STACK_DEPTH_DEF = 5;
    localparam int TICK_WIDTH_DEF  = 8;
    localparam int NUM_UNITS       = 3;
    localparam int UNIT_W          = 2;
    localparam int TAG_W           = 8;
    localparam int IN_TICK_W       = 8;
    localparam int OUT_LEFT_W      = 8;
    localparam int DEPTH_OUT_W     = 3;

    // unit code that addresses no unit
    localparam logic [UNIT_W-1:0] UNIT_NONE = 2'd0;

    // per-cycle control of one stack cell
    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

    // per-cycle control of one unit counter
    typedef struct packed {
        logic tick;
        logic load;
    } unit_ctl_t;

    // one result word
    typedef struct packed {
        logic [OUT_LEFT_W-1:0]  unit_one_left;
        logic [OUT_LEFT_W-1:0]  unit_two_left;
        logic [OUT_LEFT_W-1:0]  unit_three_left;
        logic [TAG_W-1:0]       unit_one_tag;
        logic [TAG_W-1:0]       unit_two_tag;
        logic [TAG_W-1:0]       unit_three_tag;
        logic [DEPTH_OUT_W-1:0] waiting_depth;
        logic                   overflow;
    } result_t;

endpackage
`default_nettype wire

@@ sv/tdo_stack_cell.sv @@
// One entry of the shifting overflow stack
`default_nettype none
module tdo_stack_cell
    import tdo_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire stack_ctl_t            ctl,
    input  wire logic [UNIT_W-1:0]     above_unit,
    input  wire logic [TICK_WIDTH-1:0] above_ticks,
    input  wire logic [TAG_W-1:0]      above_tag,
    input  wire logic [UNIT_W-1:0]     below_unit,
    input  wire logic [TICK_WIDTH-1:0] below_ticks,
    input  wire logic [TAG_W-1:0]      below_tag,
    output logic [UNIT_W-1:0]          unit,
    output logic [TICK_WIDTH-1:0]      ticks,
    output logic [TAG_W-1:0]           tag
);

    logic [UNIT_W-1:0]     unit_reg;
    logic [TICK_WIDTH-1:0] ticks_reg;
    logic [TAG_W-1:0]      tag_reg;

    // push moves entries away from the top, pop moves them toward it
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            unit_reg  <= above_unit;
            ticks_reg <= above_ticks;
            tag_reg   <= above_tag;
        end else if (ctl.pop) begin
            unit_reg  <= below_unit;
            ticks_reg <= below_ticks;
            tag_reg   <= below_tag;
        end
    end

    assign unit  = unit_reg;
    assign ticks = ticks_reg;
    assign tag   = tag_reg;

endmodule
`default_nettype wire

@@ sv/tdo_unit_cell.sv @@
// Remaining-count and tag register of one processing unit
`default_nettype none
module tdo_unit_cell
    import tdo_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire unit_ctl_t             ctl,
    input  wire logic [TICK_WIDTH-1:0] load_ticks,
    input  wire logic [TAG_W-1:0]      load_tag,
    output logic                       busy,
    output logic [TICK_WIDTH-1:0]      left_next,
    output logic [TAG_W-1:0]           tag_next
);

    logic [TICK_WIDTH-1:0] left_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [TICK_WIDTH-1:0] loaded;

    // load first, then count down saturating at zero
    always_comb begin
        loaded    = ctl.load ? load_ticks : left_reg;
        left_next = (loaded == '0) ? loaded : loaded - TICK_WIDTH'(1);
        tag_next  = ctl.load ? load_tag : tag_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            tag_reg  <= '0;
        end else if (ctl.tick) begin
            left_reg <= left_next;
            tag_reg  <= tag_next;
        end
    end

    assign busy = (left_reg != '0);

endmodule
`default_nettype wire

@@ sv/task_dispatch_with_overflow_stack.sv @@
// Top level: three-unit task dispatcher with an overflow stack
//
//  channel | ports    | word
//  --------+----------+------------------------------------------------
//  input   | s_*      | one tick: has_task, task_unit, task_ticks, tag
//  result  | m_*      | unit counts and tags, stack depth, overflow
//
// One tick is taken every cycle while s_ready is high; its result is
// registered. The unit counters and the stack cells all update in the
// accepting cycle, the stack top sitting in the first cell of the chain.
// A two-word output buffer (register plus skid) keeps s_ready high for one
// more word while m_ready is low; s_ready drops only when both are full.
// Synchronous active-low reset clears counts, tags, depth and the buffer.
`default_nettype none
module task_dispatch_with_overflow_stack
    import tdo_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_has_task,
    input  wire logic [UNIT_W-1:0]      s_task_unit,
    input  wire logic [IN_TICK_W-1:0]   s_task_ticks,
    input  wire logic [TAG_W-1:0]       s_task_tag,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [OUT_LEFT_W-1:0]       m_unit_one_left,
    output logic [OUT_LEFT_W-1:0]       m_unit_two_left,
    output logic [OUT_LEFT_W-1:0]       m_unit_three_left,
    output logic [TAG_W-1:0]            m_unit_one_tag,
    output logic [TAG_W-1:0]            m_unit_two_tag,
    output logic [TAG_W-1:0]            m_unit_three_tag,
    output logic [DEPTH_OUT_W-1:0]      m_waiting_depth,
    output logic                        m_overflow
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic                  accept_in;
    logic                  accept_out;
    logic [TICK_WIDTH-1:0] ticks_in;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic [UNIT_W-1:0]     cell_unit  [STACK_DEPTH];
    logic [TICK_WIDTH-1:0] cell_ticks [STACK_DEPTH];
    logic [TAG_W-1:0]      cell_tag   [STACK_DEPTH];
    stack_ctl_t            stack_ctl;

    logic [NUM_UNITS-1:0]  unit_busy;
    unit_ctl_t             unit_ctl   [NUM_UNITS];
    logic [TICK_WIDTH-1:0] unit_ticks [NUM_UNITS];
    logic [TAG_W-1:0]      unit_tag   [NUM_UNITS];
    logic [TICK_WIDTH-1:0] left_next  [NUM_UNITS];
    logic [TAG_W-1:0]      tag_next   [NUM_UNITS];

    logic                  task_ok;
    logic                  task_busy;
    logic                  load_task;
    logic                  stack_full;
    logic                  do_push;
    logic                  do_pop;
    logic                  overflow_now;

    result_t               res_next;
    result_t               out_reg;
    result_t               skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    assign accept_in  = s_valid && s_ready;
    assign accept_out = out_valid_reg && m_ready;
    assign ticks_in   = TICK_WIDTH'(s_task_ticks);

    // dispatch decision for this tick
    always_comb begin
        task_ok      = s_has_task && (s_task_unit != UNIT_NONE);
        task_busy    = task_ok && unit_busy[s_task_unit - 2'd1];
        load_task    = task_ok && !task_busy;
        stack_full   = (count_reg >= CNT_W'(STACK_DEPTH));
        do_push      = task_busy && !stack_full;
        overflow_now = task_busy && stack_full;
        do_pop       = !s_has_task && (count_reg != '0) && (cell_unit[0] != UNIT_NONE)
                       && !unit_busy[cell_unit[0] - 2'd1];
        stack_ctl.push = accept_in && do_push;
        stack_ctl.pop  = accept_in && do_pop;
        count_next = count_reg;
        if (do_push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // stack depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept_in) begin
            count_reg <= count_next;
        end
    end

    // chain of stack cells, top at cell 0
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stack
        logic [UNIT_W-1:0]     a_unit, b_unit;
        logic [TICK_WIDTH-1:0] a_ticks, b_ticks;
        logic [TAG_W-1:0]      a_tag, b_tag;

        if (i == 0) begin : g_first
            assign a_unit  = s_task_unit;
            assign a_ticks = ticks_in;
            assign a_tag   = s_task_tag;
        end else begin : g_inner
            assign a_unit  = cell_unit[i-1];
            assign a_ticks = cell_ticks[i-1];
            assign a_tag   = cell_tag[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_last
            assign b_unit  = cell_unit[i];
            assign b_ticks = cell_ticks[i];
            assign b_tag   = cell_tag[i];
        end else begin : g_mid
            assign b_unit  = cell_unit[i+1];
            assign b_ticks = cell_ticks[i+1];
            assign b_tag   = cell_tag[i+1];
        end

        tdo_stack_cell #(
            .TICK_WIDTH (TICK_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (stack_ctl),
            .above_unit  (a_unit),
            .above_ticks (a_ticks),
            .above_tag   (a_tag),
            .below_unit  (b_unit),
            .below_ticks (b_ticks),
            .below_tag   (b_tag),
            .unit        (cell_unit[i]),
            .ticks       (cell_ticks[i]),
            .tag         (cell_tag[i])
        );
    end

    // unit counters, loaded from the new task or from the popped top
    for (genvar k = 0; k < NUM_UNITS; k++) begin : g_unit
        logic sel_task;
        logic sel_pop;

        assign sel_task = load_task && (s_task_unit == UNIT_W'(k + 1));
        assign sel_pop  = do_pop && (cell_unit[0] == UNIT_W'(k + 1));

        assign unit_ctl[k].tick = accept_in;
        assign unit_ctl[k].load = sel_task || sel_pop;
        assign unit_ticks[k]    = sel_task ? ticks_in : cell_ticks[0];
        assign unit_tag[k]      = sel_task ? s_task_tag : cell_tag[0];

        tdo_unit_cell #(
            .TICK_WIDTH (TICK_WIDTH)
        ) u_unit (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (unit_ctl[k]),
            .load_ticks (unit_ticks[k]),
            .load_tag   (unit_tag[k]),
            .busy       (unit_busy[k]),
            .left_next  (left_next[k]),
            .tag_next   (tag_next[k])
        );
    end

    // result word of this tick
    always_comb begin
        res_next.unit_one_left   = OUT_LEFT_W'(left_next[0]);
        res_next.unit_two_left   = OUT_LEFT_W'(left_next[1]);
        res_next.unit_three_left = OUT_LEFT_W'(left_next[2]);
        res_next.unit_one_tag    = tag_next[0];
        res_next.unit_two_tag    = tag_next[1];
        res_next.unit_three_tag  = tag_next[2];
        res_next.waiting_depth   = DEPTH_OUT_W'(count_next);
        res_next.overflow        = overflow_now;
    end

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept_out) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else if (accept_in) begin
                    out_reg <= res_next;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (accept_in) begin
                if (!out_valid_reg) begin
                    out_reg       <= res_next;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res_next;
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign s_ready           = !skid_valid_reg;
    assign m_valid           = out_valid_reg;
    assign m_unit_one_left   = out_reg.unit_one_left;
    assign m_unit_two_left   = out_reg.unit_two_left;
    assign m_unit_three_left = out_reg.unit_three_left;
    assign m_unit_one_tag    = out_reg.unit_one_tag;
    assign m_unit_two_tag    = out_reg.unit_two_tag;
    assign m_unit_three_tag  = out_reg.unit_three_tag;
    assign m_waiting_depth   = out_reg.waiting_depth;
    assign m_overflow        = out_reg.overflow;

endmodule
`default_nettype wire

@@ sv/tdo_checker.sv @@
// Port-level checks of the task dispatcher, bound to the top level
`default_nettype none
`include "task_dispatch_with_overflow_stack_assert.svh"
module tdo_checker
    import tdo_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_ready,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [DEPTH_OUT_W-1:0] m_waiting_depth,
    input wire logic                   m_overflow
);

    localparam logic [DEPTH_OUT_W-1:0] FULL_DEPTH = DEPTH_OUT_W'(STACK_DEPTH);

    // a dropped task is only reported with the stack full
    `TDO_ASSERT_RUN(a_ovf_full, aclk, aresetn, m_valid && m_overflow |-> m_waiting_depth == FULL_DEPTH, "overflow with stack not full")

    // input stalls only when a result is held on the output
    `TDO_ASSERT_RUN(a_stall_held, aclk, aresetn, !s_ready |-> m_valid, "input stalled with no result pending")

    // reset empties the output
    `TDO_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // a stalled result keeps its word
    `TDO_ASSERT_RUN(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_waiting_depth) && $stable(m_overflow), "stalled result changed")

endmodule

bind task_dispatch_with_overflow_stack tdo_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_tdo_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_waiting_depth (m_waiting_depth),
    .m_overflow      (m_overflow)
);
`default_nettype wire
